>>> rtl/kcaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcaf_pkg
// Shared constants, codes and controller/datapath types for the keyed
// cooldown announce filter.
// ----------------------------------------------------------------------------
package kcaf_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int ID_W          = 8;
    localparam int TIME_W        = 32;
    localparam int OUTCOME_W     = 2;
    // Fill count holds 0..TABLE_ENTRIES; slot index holds 0..TABLE_ENTRIES-1.
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_KNOWN_PASSED     = 2'd0,
        OUTCOME_KNOWN_SUPPRESSED = 2'd1,
        OUTCOME_NEW_RECORDED     = 2'd2,
        OUTCOME_NEW_TABLE_FULL   = 2'd3
    } t_outcome;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic load;    // capture the accepted request, restart the scan
        logic step;    // advance to the next slot
        logic finish;  // decide, update the table, fill the output register
    } t_cmd;

    typedef struct packed {
        logic at_end;    // every used slot has been examined
        logic hit;       // current slot holds the requested ID
        logic out_free;  // output register can take a new result this cycle
    } t_status;

endpackage

>>> rtl/kcaf_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcaf_ifs
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
interface kcaf_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  message_id;
    logic [31:0] now_ms;
    logic [31:0] min_gap_ms;

    modport source (output valid, output message_id, output now_ms,
                    output min_gap_ms, input ready);
    modport sink   (input valid, input message_id, input now_ms,
                    input min_gap_ms, output ready);
endinterface

interface kcaf_rsp_if;
    logic       valid;
    logic       ready;
    logic       announce;
    logic [7:0] announced_id;
    logic [1:0] outcome;

    modport source (output valid, output announce, output announced_id,
                    output outcome, input ready);
    modport sink   (input valid, input announce, input announced_id,
                    input outcome, output ready);
endinterface

>>> rtl/keyed_cooldown_announce_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_cooldown_announce_filter
// Per-ID cooldown filter for announcement requests, one result per request.
// ----------------------------------------------------------------------------
// A request is accepted in the idle state, then the scan steps past each
// stored entry examined before the matching one (or all used entries for a
// new ID), then the decision is made. The scan reads one table slot per
// cycle and does the wrapping elapsed-time compare on the matching slot. The
// result sits in an output register, so a new request is accepted while the
// previous result still waits to be taken; the decision of that new request
// waits only if the old result is still there. The table needs no clearing
// after reset.
module keyed_cooldown_announce_filter
    import kcaf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    kcaf_req_if.sink   i_req,
    kcaf_rsp_if.source o_rsp
);

    t_cmd    w_cmd;
    t_status w_status;

    kcaf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    kcaf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_message_id   (i_req.message_id),
        .i_now_ms       (i_req.now_ms),
        .i_min_gap_ms   (i_req.min_gap_ms),
        .o_valid        (o_rsp.valid),
        .i_ready        (o_rsp.ready),
        .o_announce     (o_rsp.announce),
        .o_announced_id (o_rsp.announced_id),
        .o_outcome      (o_rsp.outcome)
    );

endmodule

>>> rtl/kcaf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcaf_ctrl
// Sequencer: accepts a request, steps the table scan and hands the decision
// to the output register when it has room.
// ----------------------------------------------------------------------------
module kcaf_ctrl
    import kcaf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.hit || i_status.at_end) begin
                    // Hold the decision until a pending result has been taken.
                    if (i_status.out_free) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == ST_IDLE)
        else $error("request captured outside idle");
    a_finish_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_status.out_free)
        else $error("result written while output register busy");
    a_finish_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == ST_IDLE)
        else $error("sequencer did not return to idle after a decision");
`endif

endmodule

>>> rtl/kcaf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcaf_dp
// Datapath: request registers, ID/time table, scan pointer, cooldown compare
// and the result register.
// ----------------------------------------------------------------------------
module kcaf_dp
    import kcaf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [ID_W-1:0]      i_message_id,
    input  logic [TIME_W-1:0]    i_now_ms,
    input  logic [TIME_W-1:0]    i_min_gap_ms,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_announce,
    output logic [ID_W-1:0]      o_announced_id,
    output logic [OUTCOME_W-1:0] o_outcome
);

    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_cool;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_count;
    logic [ID_W-1:0]   r_ent_id   [TABLE_ENTRIES];
    logic [TIME_W-1:0] r_ent_time [TABLE_ENTRIES];

    logic              r_out_valid;
    logic              r_announce;
    logic [ID_W-1:0]   r_out_id;
    t_outcome          r_outcome;

    logic [IDX_W-1:0]  w_slot;
    logic [IDX_W-1:0]  w_free_slot;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_cool_done;
    logic              w_room;

    assign w_slot      = r_idx[IDX_W-1:0];
    assign w_free_slot = r_count[IDX_W-1:0];
    // Wrapping difference: a stored time ahead of now reads as a long gap.
    assign w_elapsed   = r_now - r_ent_time[w_slot];
    assign w_cool_done = (w_elapsed >= r_cool);
    assign w_room      = (r_count < CNT_W'(TABLE_ENTRIES));

    assign o_status.at_end   = (r_idx == r_count);
    assign o_status.hit      = (r_idx != r_count) && (r_ent_id[w_slot] == r_id);
    assign o_status.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id   <= i_message_id;
            r_now  <= i_now_ms;
            r_cool <= i_min_gap_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.finish && !o_status.hit && w_room) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Table update: refresh on a passed known ID, append an unknown ID while the table has room.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (o_status.hit) begin
                if (w_cool_done) begin
                    r_ent_time[w_slot] <= r_now;
                end
            end else if (w_room) begin
                r_ent_id[w_free_slot]   <= r_id;
                r_ent_time[w_free_slot] <= r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_id <= r_id;
            if (o_status.hit) begin
                r_announce <= w_cool_done;
                r_outcome  <= w_cool_done ? OUTCOME_KNOWN_PASSED
                                          : OUTCOME_KNOWN_SUPPRESSED;
            end else begin
                r_announce <= 1'b1;
                r_outcome  <= w_room ? OUTCOME_NEW_RECORDED : OUTCOME_NEW_TABLE_FULL;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_announce     = r_announce;
    assign o_announced_id = r_out_id;
    assign o_outcome      = r_outcome;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("table fill count beyond capacity");
    a_count_grows_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> r_count == $past(r_count) + 1'b1)
        else $error("table fill count changed by other than one");
    a_step_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> !o_status.hit && !o_status.at_end)
        else $error("scan advanced past a match or the end of the table");
    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("decision did not reach the output register");
`endif

endmodule
